// File: design/cafe_pkg.sv
// ============================================================================
// cafe_pkg
// Shared widths, register indexes and types for the amplitude frame encoder.
// ============================================================================
package cafe_pkg;

    // Default build-time settings
    localparam int DEF_MAX_SUBCARRIERS = 255;
    localparam int DEF_GAIN_FRAC_BITS  = 12;

    // Field widths
    localparam int MAC_W    = 48;
    localparam int BYTE_W   = 8;
    localparam int GAIN_W   = 16;
    localparam int TS_W     = 32;
    localparam int COUNT_W  = 8;
    localparam int SUM_W    = 16;

    // Arithmetic widths: sum of squares, gain squared, product, root
    localparam int SQ_W     = 16;
    localparam int GG_W     = 2 * GAIN_W;
    localparam int PROD_W   = GG_W + SQ_W;
    localparam int RAD_W    = PROD_W + 2;
    localparam int ROOT_W   = RAD_W / 2;

    // Header bytes summed serially: six address bytes, rssi, noise, timestamp
    localparam int HDR_BYTES = 12;
    localparam int HDR_CNT_W = 4;

    localparam logic [SUM_W-1:0]   FRAME_VERSION = 16'd1;
    localparam logic [BYTE_W-1:0]  AMP_MAX       = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hFF;

    // Stream words
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 40;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 48;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSMIT_ROLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MAC    = 1'b1;

    // Item kinds carried in s_tuser
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Square-root unit status toward the controller
    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } cafe_root_status_t;

endpackage

// File: design/cafe_isqrt.sv
// ============================================================================
// cafe_isqrt
// Bit-serial restoring square root: two radicand bits in, one root bit out
// per cycle. Gives the floor of the root once all ROOT_W root bits are formed.
// ============================================================================
module cafe_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cafe_pkg::RAD_W-1:0]    radicand,
    output cafe_pkg::cafe_root_status_t   status
);
    import cafe_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;

    logic [ROOT_W+1:0]   rem_shift;
    logic [ROOT_W+1:0]   trial;
    logic                fits;

    // One recurrence step: bring down two bits, try subtracting 4*root+1
    assign rem_shift = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = fits ? (rem_shift - trial) : rem_shift;
            root_next = {root_reg[ROOT_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign status.done = done_reg;
    assign status.root = root_reg;

`ifndef SYNTHESIS
    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("root unit started while busy");
    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("root done held for more than one cycle");
    a_busy_from_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy_reg) |-> $past(start))
        else $error("root unit went busy without a start");
`endif

endmodule

// File: design/csi_amplitude_frame_encoder.sv
// ============================================================================
// csi_amplitude_frame_encoder
// Turns per-subcarrier channel estimates into an amplitude frame. A header
// word (s_tuser = 0) opens a packet; it is kept only when the transmit role is
// clear and its sender address equals the filter address. Each sample word
// (s_tuser = 1) of a kept packet yields one result word holding the rounded,
// gain-scaled magnitude, saturated to 255; the word with s_tlast set also
// carries the sample count, the clipped count and the frame checksum, and
// closes the packet. A header's twelve bytes are added to the checksum one
// at a time. A counted sample waits on the bit-serial square root, which
// produces one of its 25 root bits per cycle; samples past MAX_SUBCARRIERS
// give a zero amplitude with m_tuser clear; samples of dropped packets are discarded.
// A finished result waits in the output register while the next word is
// accepted. Configuration writes are taken every cycle.
// ============================================================================
module csi_amplitude_frame_encoder #(
    parameter int MAX_SUBCARRIERS = cafe_pkg::DEF_MAX_SUBCARRIERS,
    parameter int GAIN_FRAC_BITS  = cafe_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cafe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cafe_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // packet_mac[47:0], rssi[55:48], noise_level[63:56], timestamp[95:64],
    // first_word_bad[96], gain[112:97], imag_part[120:113],
    // real_part[128:121], zero fill[135:129]
    input  logic [cafe_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,   // command
    input  logic                               s_tlast,   // final_sample
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // amplitude[7:0], sample_count[15:8], clipped_count[23:16],
    // checksum[39:24]
    output logic [cafe_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser,   // amplitude_valid
    output logic                               m_tlast    // end_of_frame
);
    import cafe_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HDR   = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_START = 6'b001000,
        ST_ROOT  = 6'b010000,
        ST_OUT   = 6'b100000
    } cafe_state_t;

    localparam logic [ROOT_W:0] ROUND_HALF = (ROOT_W + 1)'(1) << GAIN_FRAC_BITS;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_SUBCARRIERS);

    cafe_state_t             state_reg, state_next;
    logic                    role_reg, role_next;
    logic [MAC_W-1:0]        filter_reg, filter_next;
    logic                    kept_reg, kept_next;
    logic [GAIN_W-1:0]       gain_reg, gain_next;
    logic [GG_W-1:0]         gg_reg;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [COUNT_W-1:0]      clips_reg, clips_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [HDR_BYTES*BYTE_W-1:0] hdr_sr_reg, hdr_sr_next;
    logic [HDR_CNT_W-1:0]    hdr_cnt_reg, hdr_cnt_next;
    logic                    final_reg, final_next;
    logic                    amp_en_reg, amp_en_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;
    logic                    m_tlast_reg, m_tlast_next;

    logic                    s_accept;
    logic                    out_free;
    logic signed [BYTE_W-1:0]   imag_in, real_in;
    logic signed [2*BYTE_W-1:0] imag_sq, real_sq;
    logic [SQ_W-1:0]         sq_in;
    logic [ROOT_W:0]         amp_sum, amp_wide;
    logic                    amp_clip;
    logic [BYTE_W-1:0]       amp_byte;
    logic [COUNT_W-1:0]      count_new, clips_new;
    logic [SUM_W-1:0]        sum_new, checksum;
    logic                    root_start;
    cafe_root_status_t       root_st;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Sum of squares straight from the input word
    assign imag_in = $signed(s_tdata[120:113]);
    assign real_in = $signed(s_tdata[128:121]);
    assign imag_sq = imag_in * imag_in;
    assign real_sq = real_in * real_in;
    assign sq_in   = SQ_W'($unsigned(imag_sq)) + SQ_W'($unsigned(real_sq));

    // Round, scale down and saturate the root
    assign amp_sum  = {1'b0, root_st.root} + ROUND_HALF;
    assign amp_wide = amp_sum >> (GAIN_FRAC_BITS + 1);
    assign amp_clip = (amp_wide > (ROOT_W + 1)'(AMP_MAX));
    assign amp_byte = !amp_en_reg ? '0 : (amp_clip ? AMP_MAX : amp_wide[BYTE_W-1:0]);

    // Frame statistics after this sample
    assign count_new = amp_en_reg ? count_reg + 1'b1 : count_reg;
    assign clips_new = (amp_en_reg && amp_clip && (clips_reg != COUNT_MAX))
                     ? clips_reg + 1'b1 : clips_reg;
    assign sum_new   = sum_reg + SUM_W'(amp_byte);
    assign checksum  = sum_new + SUM_W'(count_new) + SUM_W'(clips_new);

    assign root_start = (state_reg == ST_START);

    cafe_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand ({prod_reg, 2'b00}),
        .status   (root_st)
    );

    always_comb begin
        state_next    = state_reg;
        role_next     = role_reg;
        filter_next   = filter_reg;
        kept_next     = kept_reg;
        gain_next     = gain_reg;
        sq_next       = sq_reg;
        prod_next     = prod_reg;
        count_next    = count_reg;
        clips_next    = clips_reg;
        sum_next      = sum_reg;
        hdr_sr_next   = hdr_sr_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        final_next    = final_reg;
        amp_en_next   = amp_en_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        // Register writes
        if (cfg_valid) begin
            case (cfg_index)
                REG_TRANSMIT_ROLE: role_next   = cfg_data[0];
                REG_FILTER_MAC:    filter_next = cfg_data[MAC_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == CMD_HEADER) begin
                        // Open a packet; header bytes are summed one per cycle
                        kept_next    = !role_reg && (s_tdata[MAC_W-1:0] == filter_reg);
                        gain_next    = s_tdata[112:97];
                        count_next   = '0;
                        clips_next   = '0;
                        sum_next     = FRAME_VERSION + SUM_W'(s_tdata[96]);
                        hdr_sr_next  = s_tdata[HDR_BYTES*BYTE_W-1:0];
                        hdr_cnt_next = '0;
                        state_next   = ST_HDR;
                    end else if (kept_reg) begin
                        final_next  = s_tlast;
                        sq_next     = sq_in;
                        amp_en_next = (count_reg < COUNT_LIMIT);
                        state_next  = (count_reg < COUNT_LIMIT) ? ST_MUL : ST_OUT;
                    end
                end
            end
            ST_HDR: begin
                sum_next     = sum_reg + SUM_W'(hdr_sr_reg[BYTE_W-1:0]);
                hdr_sr_next  = hdr_sr_reg >> BYTE_W;
                hdr_cnt_next = hdr_cnt_reg + 1'b1;
                if (hdr_cnt_reg == HDR_CNT_W'(HDR_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                prod_next  = gg_reg * sq_reg;
                state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_st.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hand the result over once the output register is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = amp_en_reg;
                    m_tlast_next  = final_reg;
                    m_tdata_next  = final_reg
                                  ? {checksum, clips_new, count_new, amp_byte}
                                  : {SUM_W'(0), COUNT_W'(0), COUNT_W'(0), amp_byte};
                    count_next    = count_new;
                    clips_next    = clips_new;
                    sum_next      = sum_new;
                    if (final_reg) begin
                        kept_next = 1'b0;
                    end
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            role_reg     <= 1'b0;
            filter_reg   <= '0;
            kept_reg     <= 1'b0;
            count_reg    <= '0;
            clips_reg    <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            role_reg     <= role_next;
            filter_reg   <= filter_next;
            kept_reg     <= kept_next;
            count_reg    <= count_next;
            clips_reg    <= clips_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        gain_reg    <= gain_next;
        gg_reg      <= gain_reg * gain_reg;
        sq_reg      <= sq_next;
        prod_reg    <= prod_next;
        hdr_sr_reg  <= hdr_sr_next;
        hdr_cnt_reg <= hdr_cnt_next;
        final_reg   <= final_next;
        amp_en_reg  <= amp_en_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_invalid_amp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == '0))
        else $error("excess subcarrier word carries a nonzero amplitude");
    a_clips_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[23:16] <= m_tdata[15:8]))
        else $error("clipped count exceeds sample count");
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[15:8] <= COUNT_LIMIT))
        else $error("sample count beyond subcarrier limit");
    a_root_done_awaited: assert property (@(posedge aclk) disable iff (!aresetn)
        root_st.done |-> (state_reg == ST_ROOT))
        else $error("root finished while controller was not waiting");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for csi_amplitude_frame_encoder. A stimulus process
// fills a queue of header and sample words (a directed opening, then random
// packets over several flow-control phases). A clocked driver presents them
// on the input stream. At each accepted word a bit-accurate frame model
// predicts the result word, if any. A clocked monitor compares every
// accepted result word field by field with the oldest prediction.
// ============================================================================
module tb_top;
    import cafe_pkg::*;

    localparam int FRAC_BITS       = DEF_GAIN_FRAC_BITS;
    localparam int MAX_SUBC        = DEF_MAX_SUBCARRIERS;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 3000;

    // One input word, unpacked into its fields
    typedef struct {
        logic               cmd;
        logic [MAC_W-1:0]   mac;
        logic [7:0]         rssi;
        logic [7:0]         noise;
        logic [TS_W-1:0]    ts;
        logic               fwi;
        logic [GAIN_W-1:0]  gain;
        logic [7:0]         im_v;
        logic [7:0]         re_v;
        logic               fin;
    } in_word_t;

    // One result word
    typedef struct {
        logic [7:0]         amplitude;
        logic               amp_ok;
        logic               eof;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] clips;
        logic [SUM_W-1:0]   csum;
    } frame_word_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // Traffic shaping
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        hold_start    = 1'b0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    int          fail_count    = 0;

    in_word_t    word_queue[$];
    in_word_t    cur_word;
    frame_word_t frame_words_due[$];

    // Frame model state and its copy of the registers
    logic               tx_role     = 1'b0;
    logic [MAC_W-1:0]   accept_mac  = '0;
    logic               frame_open  = 1'b0;
    logic [GAIN_W-1:0]  frame_gain  = '0;
    logic [COUNT_W-1:0] frame_count = '0;
    logic [COUNT_W-1:0] frame_clips = '0;
    logic [SUM_W-1:0]   frame_sum   = '0;

    csi_amplitude_frame_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Floor of the square root, one result bit per pass
    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[31:0];
    endfunction

    // Advance the frame model by one accepted word; queue the result it yields
    task automatic frame_encode(input in_word_t w);
        frame_word_t r;
        logic [SUM_W-1:0] hsum;
        logic [63:0]      sq;
        logic [63:0]      g;
        logic [31:0]      amp;
        int               im;
        int               re;
        if (w.cmd == CMD_HEADER) begin
            hsum = FRAME_VERSION;
            for (int j = 0; j < 6; j++)
                hsum += SUM_W'(w.mac[8*j +: 8]);
            hsum += SUM_W'(w.rssi);
            hsum += SUM_W'(w.noise);
            for (int j = 0; j < 4; j++)
                hsum += SUM_W'(w.ts[8*j +: 8]);
            hsum += SUM_W'(w.fwi);
            frame_open  = !tx_role && (w.mac == accept_mac);
            frame_gain  = w.gain;
            frame_count = '0;
            frame_clips = '0;
            frame_sum   = hsum;
        end else if (frame_open) begin
            r = '{default: '0};
            if (frame_count < MAX_SUBC) begin
                im  = int'($signed(w.im_v));
                re  = int'($signed(w.re_v));
                sq  = 64'(im * im + re * re);
                g   = 64'(frame_gain);
                amp = (floor_sqrt(64'd4 * g * g * sq) + (32'd1 << FRAC_BITS))
                      >> (FRAC_BITS + 1);
                if (amp > 32'(AMP_MAX)) begin
                    amp = 32'(AMP_MAX);
                    if (frame_clips < COUNT_MAX)
                        frame_clips++;
                end
                frame_count++;
                frame_sum  += SUM_W'(amp[7:0]);
                r.amplitude = amp[7:0];
                r.amp_ok    = 1'b1;
            end
            if (w.fin) begin
                r.eof      = 1'b1;
                r.count    = frame_count;
                r.clips    = frame_clips;
                r.csum     = frame_sum + SUM_W'(frame_count) + SUM_W'(frame_clips);
                frame_open = 1'b0;
            end
            frame_words_due.push_back(r);
        end
    endtask

    // Input stream driver: hold a word until accepted, then maybe idle
    always @(posedge aclk) begin : word_driver
        logic busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                frame_encode(cur_word);
                busy = 1'b0;
            end
            if (!busy) begin
                if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = word_queue.pop_front();
                    s_tdata  <= {7'b0, cur_word.re_v, cur_word.im_v, cur_word.gain,
                                 cur_word.fwi, cur_word.ts, cur_word.noise,
                                 cur_word.rssi, cur_word.mac};
                    s_tuser  <= cur_word.cmd;
                    s_tlast  <= cur_word.fin;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    // Long receiver hold-off, counted down here
    always @(posedge aclk) begin
        if (hold_start)
            hold_left <= HOLD_OFF_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result stream monitor: compare each word with the oldest prediction
    always @(posedge aclk) begin : result_monitor
        frame_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_words_due.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want = frame_words_due.pop_front();
                    check_field("amplitude", 16'(want.amplitude), 16'(m_tdata[7:0]));
                    check_field("amplitude_valid", 16'(want.amp_ok), 16'(m_tuser));
                    check_field("end_of_frame", 16'(want.eof), 16'(m_tlast));
                    check_field("sample_count", 16'(want.count), 16'(m_tdata[15:8]));
                    check_field("clipped_count", 16'(want.clips), 16'(m_tdata[23:16]));
                    check_field("checksum", want.csum, m_tdata[39:24]);
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TRANSMIT_ROLE)
            tx_role = value[0];
        else
            accept_mac = value;
    endtask

    // Wait until the queue is sent and every result is in, then let the block finish
    task automatic settle_block();
        while (word_queue.size() != 0 || s_tvalid || frame_words_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Build a word with every field random, so unused fields carry noise
    function automatic in_word_t junk_word();
        in_word_t    w;
        logic [63:0] r;
        r      = {$urandom, $urandom};
        w.cmd  = 1'($urandom);
        w.mac  = r[MAC_W-1:0];
        w.rssi = 8'($urandom);
        w.noise = 8'($urandom);
        w.ts   = $urandom;
        w.fwi  = 1'($urandom);
        w.gain = GAIN_W'($urandom);
        w.im_v = 8'($urandom);
        w.re_v = 8'($urandom);
        w.fin  = 1'($urandom);
        return w;
    endfunction

    task automatic push_header(input logic [MAC_W-1:0] mac, input logic [7:0] rssi,
                               input logic [7:0] noise, input logic [TS_W-1:0] ts,
                               input logic fwi, input logic [GAIN_W-1:0] gain);
        in_word_t w;
        w       = junk_word();
        w.cmd   = CMD_HEADER;
        w.mac   = mac;
        w.rssi  = rssi;
        w.noise = noise;
        w.ts    = ts;
        w.fwi   = fwi;
        w.gain  = gain;
        word_queue.push_back(w);
    endtask

    task automatic push_sample(input logic [7:0] im_v, input logic [7:0] re_v,
                               input logic fin);
        in_word_t w;
        w      = junk_word();
        w.cmd  = CMD_SAMPLE;
        w.im_v = im_v;
        w.re_v = re_v;
        w.fin  = fin;
        word_queue.push_back(w);
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[MAC_W-1:0];
    endfunction

    // Loud levels always clip at full gain; otherwise mix small and full-range
    function automatic logic [7:0] pick_level(input logic loud);
        logic [7:0] v;
        if (loud) begin
            v = 8'($urandom_range(127, 64));
            return $urandom_range(1) ? -v : v;
        end
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(16) - 8);
        return 8'($urandom);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(8191));
        endcase
    endfunction

    task automatic send_packet(input logic match, input int n, input logic closed,
                               input logic [GAIN_W-1:0] gain, input logic loud);
        logic [MAC_W-1:0] mac;
        mac = match ? accept_mac : accept_mac ^ (48'd1 << $urandom_range(47));
        push_header(mac, 8'($urandom), 8'($urandom), $urandom, 1'($urandom), gain);
        for (int i = 0; i < n; i++)
            push_sample(pick_level(loud), pick_level(loud), closed && (i == n - 1));
    endtask

    // Mostly kept, closed packets; some foreign, abandoned or stray words
    task automatic random_traffic(input int budget);
        int kept_items;
        int n;
        int pick;
        kept_items = 0;
        while (kept_items < budget) begin
            pick = $urandom_range(19);
            n    = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
            if (pick == 0) begin
                push_sample(pick_level(1'b0), pick_level(1'b0), 1'($urandom_range(1)));
            end else begin
                send_packet(pick != 1, n, pick != 2, pick_gain(), 1'b0);
                if (pick != 1)
                    kept_items += n + 1;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Sample with no packet open
        push_sample(8'h7F, 8'h80, 1'b1);
        // Matching header with extreme side fields, unity gain
        push_header(48'h0, 8'h80, 8'h7F, 32'hFFFF_FFFF, 1'b1, 16'h1000);
        push_sample(8'h80, 8'h80, 1'b0);
        push_sample(8'h7F, 8'h80, 1'b0);
        push_sample(8'h00, 8'h00, 1'b0);
        push_sample(8'hFF, 8'h01, 1'b0);
        push_sample(8'h80, 8'h00, 1'b1);
        // Sample after the frame closed
        push_sample(8'h10, 8'h10, 1'b1);
        // Full-scale gain: clip, zero and a small magnitude
        push_header(48'h0, 8'h7F, 8'h80, 32'h0, 1'b0, 16'hFFFF);
        push_sample(8'h7F, 8'h7F, 1'b0);
        push_sample(8'h00, 8'h00, 1'b0);
        push_sample(8'h01, 8'h00, 1'b1);
        // Foreign sender address: dropped
        push_header(48'h1, 8'h00, 8'h00, 32'h1234_5678, 1'b0, 16'h1000);
        push_sample(8'h20, 8'h20, 1'b0);
        push_sample(8'h20, 8'h20, 1'b1);
        // Zero gain
        push_header(48'h0, 8'h01, 8'hFF, 32'h8000_0001, 1'b1, 16'h0000);
        push_sample(8'h7F, 8'h80, 1'b1);
        // A new header abandons an open frame; leave the second one open
        push_header(48'h0, 8'h55, 8'hAA, 32'h0F0F_0F0F, 1'b0, 16'h1800);
        push_sample(8'h30, 8'hD0, 1'b0);
        push_header(48'h0, 8'hAA, 8'h55, 32'hF0F0_F0F0, 1'b1, 16'h0800);
        push_sample(8'h05, 8'h03, 1'b0);
        push_sample(8'hFB, 8'h0C, 1'b0);
        settle_block();
        // Filter change while a frame is open takes effect at the next header
        write_register(REG_FILTER_MAC, '1);
        push_sample(8'h40, 8'h40, 1'b0);
        push_sample(8'h81, 8'h7F, 1'b1);
        settle_block();
        // Transmit role drops everything
        write_register(REG_TRANSMIT_ROLE, CFG_DATA_W'(1));
        push_header('1, 8'h00, 8'h00, 32'h0, 1'b0, 16'h1000);
        push_sample(8'h10, 8'h10, 1'b1);
        settle_block();
        write_register(REG_TRANSMIT_ROLE, '0);

        // No idling; one frame runs past the subcarrier limit and ends there;
        // the receiver holds off so the block backs up into the input
        random_traffic(120);
        send_packet(1'b1, MAX_SUBC + 2, 1'b1, GAIN_W'($urandom_range(8191)), 1'b0);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        settle_block();

        // Sender idles often; then a stretch in the transmit role
        write_register(REG_FILTER_MAC, rand_mac());
        send_idle_pct <= 67;
        random_traffic(180);
        settle_block();
        write_register(REG_TRANSMIT_ROLE, CFG_DATA_W'(1));
        random_traffic(30);
        settle_block();
        write_register(REG_TRANSMIT_ROLE, '0);

        // Receiver stalls often; a full frame that clips on every subcarrier
        write_register(REG_FILTER_MAC, '0);
        send_idle_pct <= 0;
        stall_pct     <= 67;
        send_packet(1'b1, MAX_SUBC, 1'b1, '1, 1'b1);
        random_traffic(120);
        settle_block();

        // Light idling on both sides
        write_register(REG_FILTER_MAC, rand_mac());
        send_idle_pct <= 10;
        stall_pct     <= 10;
        random_traffic(100);
        settle_block();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
